// File: sv/alt_pkg.sv
// ----------------------------------------------------------------------------
// alt_pkg: shared types and constants of the assembler line tokenizer
// Transfer payloads, configuration set, classified character and limits.
// ----------------------------------------------------------------------------
package alt_pkg;

	// line limits
	localparam int MAX_TOKENS   = 128;
	localparam int BUFFER_BYTES = 512;
	localparam int CUR_W        = $clog2(MAX_TOKENS + 1);
	localparam int BYTE_W       = $clog2(BUFFER_BYTES + 1);

	// results per character and result count width
	localparam int MAX_RES = 3;
	localparam int RES_W   = $clog2(MAX_RES + 1);

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_DELIM_A = 2'd0;
	localparam logic [1:0] REG_DELIM_B = 2'd1;
	localparam logic [1:0] REG_DELIM_C = 2'd2;
	localparam logic [1:0] REG_DELIM_D = 2'd3;

	localparam logic [7:0] DELIM_A_RST = 8'd44;
	localparam logic [7:0] DELIM_B_RST = 8'd32;
	localparam logic [7:0] DELIM_C_RST = 8'd9;
	localparam logic [7:0] DELIM_D_RST = 8'd10;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_SEMI   = 8'h3b;

	// result kinds
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_LINE = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       line_end;
	} in_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [6:0] token_index;
		logic [7:0] out_char;
		logic       token_empty;
		logic [7:0] token_count;
		logic       overflow;
		logic       last;
	} out_t;

	typedef struct packed {
		logic [7:0] delim_a;
		logic [7:0] delim_b;
		logic [7:0] delim_c;
		logic [7:0] delim_d;
	} cfg_t;

	// character with its classification, as queued between front and back
	typedef struct packed {
		logic [7:0] code;
		logic       line_end;
		logic       is_delim;
		logic       is_space;
		logic       is_dot;
		logic       is_quote;
		logic       is_lparen;
		logic       is_rparen;
		logic       is_comment;
		logic       quote_delim;
	} cls_t;

endpackage

// File: sv/alt_front.sv
// ----------------------------------------------------------------------------
// alt_front: input side of the tokenizer
// Takes characters, classifies them against the delimiter set, queues them.
// ----------------------------------------------------------------------------
module alt_front (
	input  logic          in_valid,
	input  alt_pkg::in_t  in_data,
	output logic          in_stall,
	input  alt_pkg::cfg_t cfg,
	input  logic          q_full,
	output logic          push,
	output alt_pkg::cls_t push_data
);
	import alt_pkg::*;

	function automatic logic f_delim(cfg_t c, logic [7:0] ch);
		return (ch != CH_NUL) && (ch == c.delim_a || ch == c.delim_b ||
			ch == c.delim_c || ch == c.delim_d);
	endfunction

	logic [7:0] ch;

	assign ch       = in_data.char_code;
	assign in_stall = q_full;

	// a zero character without line end changes nothing, so it is not queued
	assign push = in_valid && !q_full && (in_data.line_end || ch != CH_NUL);

	always_comb begin
		push_data             = '0;
		push_data.code        = ch;
		push_data.line_end    = in_data.line_end;
		push_data.is_delim    = f_delim(cfg, ch);
		push_data.is_space    = ch inside {CH_SPACE, [CH_TAB:CH_CR]};
		push_data.is_dot      = ch == CH_DOT;
		push_data.is_quote    = ch == CH_QUOTE;
		push_data.is_lparen   = ch == CH_LPAREN;
		push_data.is_rparen   = ch == CH_RPAREN;
		push_data.is_comment  = ch inside {CH_STAR, CH_SEMI};
		push_data.quote_delim = f_delim(cfg, CH_QUOTE);
	end

endmodule

// File: sv/alt_queue.sv
// ----------------------------------------------------------------------------
// alt_queue: short queue of classified characters
// Decouples the front from the back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module alt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  alt_pkg::cls_t push_data,
	output logic          full,
	output logic          head_valid,
	output alt_pkg::cls_t head,
	input  logic          pop
);
	import alt_pkg::*;

	function automatic logic [QPTR_W-1:0] f_next(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	cls_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full       = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= f_next(wr_q);
			end
			if (pop) begin
				rd_q <= f_next(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

// File: sv/alt_back.sv
// ----------------------------------------------------------------------------
// alt_back: tokenizer scan engine and result sequencer
// Applies one queued character per cycle, when no results wait, to the line
// state; hands out the up to three results it causes, one per unstalled cycle.
// ----------------------------------------------------------------------------
module alt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  alt_pkg::cls_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output alt_pkg::out_t out_data
);
	import alt_pkg::*;

	typedef enum logic [7:0] {
		MODE_LINE    = 8'b0000_0001,
		MODE_LEAD    = 8'b0000_0010,
		MODE_GAP     = 8'b0000_0100,
		MODE_FIRST   = 8'b0000_1000,
		MODE_BODY    = 8'b0001_0000,
		MODE_OPEN    = 8'b0010_0000,
		MODE_COMMENT = 8'b0100_0000,
		MODE_STOP    = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic              quoted;
		logic [7:0]        depth;
		logic [CUR_W-1:0]  cur;
		logic [BYTE_W-1:0] bytes;
		logic [CUR_W-1:0]  done;
		logic              hide;
		logic              ovf;
		logic              has;
	} scan_t;

	typedef struct packed {
		scan_t                 st;
		out_t [MAX_RES-1:0]    res;
		logic [RES_W-1:0]      n;
		logic                  ok;
	} ctx_t;

	function automatic scan_t f_clear();
		scan_t s;
		s        = '0;
		s.mode   = MODE_LINE;
		return s;
	endfunction

	function automatic ctx_t f_put(ctx_t x, logic [1:0] kind, logic [6:0] idx,
			logic [7:0] ch, logic emp, logic [7:0] cnt, logic ov);
		out_t r;
		r.result_kind = kind;
		r.token_index = idx;
		r.out_char    = ch;
		r.token_empty = emp;
		r.token_count = cnt;
		r.overflow    = ov;
		r.last        = 1'b0;
		if (x.n < RES_W'(MAX_RES)) begin
			x.res[x.n] = r;
			x.n        = x.n + 1'b1;
		end
		return x;
	endfunction

	function automatic ctx_t f_end_token(ctx_t x);
		x = f_put(x, KIND_END, 7'(x.st.cur), CH_NUL, x.st.hide || !x.st.has,
			8'd0, 1'b0);
		x.st.done = x.st.done + 1'b1;
		if (x.st.bytes < BYTE_W'(BUFFER_BYTES)) begin
			x.st.bytes = x.st.bytes + 1'b1;
		end
		x.st.cur  = x.st.cur + 1'b1;
		x.st.hide = 1'b0;
		x.st.has  = 1'b0;
		x.st.mode = MODE_GAP;
		return x;
	endfunction

	function automatic ctx_t f_cut(ctx_t x);
		x.st.ovf  = 1'b1;
		x.st.mode = MODE_STOP;
		return x;
	endfunction

	// one buffer byte; a full buffer closes the token and stops the line
	function automatic ctx_t f_store(ctx_t x, logic [7:0] ch, logic visible);
		if (x.st.bytes >= BYTE_W'(BUFFER_BYTES - 1)) begin
			x    = f_end_token(x);
			x    = f_cut(x);
			x.ok = 1'b0;
		end else begin
			x.st.bytes = x.st.bytes + 1'b1;
			if (visible && !x.st.hide) begin
				x         = f_put(x, KIND_CHAR, 7'(x.st.cur), ch, 1'b0, 8'd0, 1'b0);
				x.st.has  = 1'b1;
			end
			x.ok = 1'b1;
		end
		return x;
	endfunction

	function automatic ctx_t f_open_slot(ctx_t x);
		if (x.st.cur >= CUR_W'(MAX_TOKENS) || x.st.bytes >= BYTE_W'(BUFFER_BYTES)) begin
			x    = f_cut(x);
			x.ok = 1'b0;
		end else begin
			x.st.depth = '0;
			x.st.hide  = 1'b0;
			x.st.has   = 1'b0;
			x.ok       = 1'b1;
		end
		return x;
	endfunction

	function automatic ctx_t f_body(ctx_t x, cls_t k);
		logic shielded;
		// only a positive depth or an open quote protects a delimiter
		shielded = (!x.st.depth[7] && x.st.depth != '0) || x.st.quoted;
		if (k.is_delim && !shielded) begin
			x = f_end_token(x);
			if (k.is_dot) begin
				x = f_open_slot(x);
				if (x.ok) begin
					x.st.mode = MODE_BODY;
					x         = f_store(x, k.code, 1'b1);
				end
			end
		end else begin
			x = f_store(x, k.code, 1'b1);
			if (x.ok) begin
				if (k.is_quote) begin
					x.st.quoted = !x.st.quoted;
				end
				if (k.is_lparen && x.st.depth != 8'h7f) begin
					x.st.depth = x.st.depth + 1'b1;
				end else if (k.is_rparen && x.st.depth != 8'h80) begin
					x.st.depth = x.st.depth - 1'b1;
				end
			end
		end
		return x;
	endfunction

	function automatic ctx_t f_opening(ctx_t x, cls_t k);
		x.st.mode = MODE_BODY;
		if (k.is_delim && k.is_dot) begin
			x = f_store(x, k.code, 1'b1);
		end else begin
			x = f_body(x, k);
		end
		return x;
	endfunction

	function automatic ctx_t f_start(ctx_t x, cls_t k);
		x = f_open_slot(x);
		if (x.ok) begin
			if (k.is_quote) begin
				x.st.mode = MODE_FIRST;
			end else begin
				x = f_opening(x, k);
			end
		end
		return x;
	endfunction

	// held opening quote is then handled like an ordinary token body character
	function automatic ctx_t f_release(ctx_t x, cls_t qk);
		x.st.mode = MODE_BODY;
		x         = f_body(x, qk);
		return x;
	endfunction

	function automatic ctx_t f_step(scan_t s, cls_t k);
		ctx_t             x;
		cls_t             qk;
		logic             skip;
		logic [RES_W-1:0] li;
		x           = '0;
		x.st        = s;
		skip        = 1'b0;
		qk          = '0;
		qk.code     = CH_QUOTE;
		qk.is_delim = k.quote_delim;
		qk.is_quote = 1'b1;
		if (k.line_end) begin
			if (x.st.mode == MODE_FIRST) begin
				x = f_release(x, qk);
			end
			if (x.st.mode == MODE_BODY || x.st.mode == MODE_OPEN ||
					x.st.mode == MODE_FIRST) begin
				x = f_end_token(x);
			end
			x    = f_put(x, KIND_LINE, 7'd0, CH_NUL, 1'b0, 8'(x.st.done), x.st.ovf);
			x.st = f_clear();
		end else begin
			if (x.st.mode == MODE_FIRST) begin
				if (k.is_quote) begin
					// two quotes: empty token, rest consumed silently
					x = f_store(x, CH_NUL, 1'b0);
					if (x.ok) begin
						x.st.hide = 1'b1;
						x.st.mode = MODE_OPEN;
					end
					skip = 1'b1;
				end else begin
					x = f_release(x, qk);
				end
			end
			if (!skip) begin
				case (x.st.mode)
					MODE_LINE, MODE_LEAD: begin
						if (k.is_space) begin
							x.st.mode = MODE_LEAD;
						end else if (k.is_comment) begin
							x.st.mode = MODE_COMMENT;
						end else begin
							x.st.cur = (x.st.mode == MODE_LEAD) ? CUR_W'(1) : '0;
							x        = f_start(x, k);
						end
					end
					MODE_GAP: begin
						if (!k.is_space) begin
							x = f_start(x, k);
						end
					end
					MODE_OPEN: begin
						x = f_opening(x, k);
					end
					MODE_BODY: begin
						x = f_body(x, k);
					end
					default: begin
					end
				endcase
			end
		end
		li = x.n - 1'b1;
		if (x.n != '0) begin
			x.res[li].last = 1'b1;
		end
		return x;
	endfunction

	scan_t                st_q;
	ctx_t                 step;
	out_t                 out_q;
	logic                 out_valid_q;
	out_t [MAX_RES-2:0]   pend_q;
	logic [RES_W-1:0]     pend_n_q;
	logic                 out_free;

	assign step      = f_step(st_q, head);
	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = head_valid && (pend_n_q == '0) && (out_free || step.n == '0);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= f_clear();
			out_valid_q <= 1'b0;
			pend_n_q    <= '0;
		end else begin
			if (pop) begin
				st_q <= step.st;
			end
			if (pend_n_q != '0 && out_free) begin
				out_valid_q <= 1'b1;
				pend_n_q    <= pend_n_q - 1'b1;
			end else if (pop && step.n != '0) begin
				out_valid_q <= 1'b1;
				pend_n_q    <= step.n - 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_n_q != '0 && out_free) begin
			out_q     <= pend_q[0];
			pend_q[0] <= pend_q[1];
		end else if (pop && step.n != '0) begin
			out_q  <= step.res[0];
			pend_q <= step.res[MAX_RES-1:1];
		end
	end

endmodule

// File: sv/assembler_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// assembler_line_tokenizer_unit: source line tokenizer
// Splits a character stream into numbered token characters and token ends.
// ----------------------------------------------------------------------------
// Feed one character per transfer and close each line with a line_end
// transfer; the unit answers with token characters, token ends and one line
// end summary (token count, overflow), the last result of each input
// transfer being flagged. A new character is taken every clock unless the
// queue is full: the front classifies it against the four delimiter
// registers in the cycle it arrives and parks it in a four-entry queue, the
// back applies it to the line state and loads its first result into the
// output register. A character that causes two or three results holds the
// back, since the output register delivers one result per clock while
// out_stall is low; the queue absorbs such bursts and any stall on the
// result side. Zero characters without line end are taken and dropped.
// There is no start-up clearing pass. Delimiter registers sit at byte
// addresses 0, 4, 8 and 12 and are only to be written while the unit is idle.
module assembler_line_tokenizer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// character input
	input  logic                         in_valid,
	output logic                         in_stall,
	input  alt_pkg::in_t                 in_data,
	// token results
	output logic                         out_valid,
	input  logic                         out_stall,
	output alt_pkg::out_t                out_data,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [alt_pkg::ADDR_W-1:0]   paddr,
	input  logic [alt_pkg::DATA_W-1:0]   pwdata,
	output logic [alt_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import alt_pkg::*;

	cfg_t       cfg_q;
	logic       cfg_wr;
	logic [1:0] reg_idx;
	logic [7:0] rd_byte;

	logic       q_full;
	logic       q_push;
	cls_t       q_push_data;
	logic       q_head_valid;
	cls_t       q_head;
	logic       q_pop;

	// register port: no wait states, word index taken from the address
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim_a <= DELIM_A_RST;
			cfg_q.delim_b <= DELIM_B_RST;
			cfg_q.delim_c <= DELIM_C_RST;
			cfg_q.delim_d <= DELIM_D_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DELIM_A: cfg_q.delim_a <= pwdata[7:0];
				REG_DELIM_B: cfg_q.delim_b <= pwdata[7:0];
				REG_DELIM_C: cfg_q.delim_c <= pwdata[7:0];
				REG_DELIM_D: cfg_q.delim_d <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// read back of the delimiter registers
	always_comb begin
		case (reg_idx)
			REG_DELIM_A: rd_byte = cfg_q.delim_a;
			REG_DELIM_B: rd_byte = cfg_q.delim_b;
			REG_DELIM_C: rd_byte = cfg_q.delim_c;
			REG_DELIM_D: rd_byte = cfg_q.delim_d;
			default:     rd_byte = CH_NUL;
		endcase
	end

	assign prdata = DATA_W'(rd_byte);

	// front: classify and queue each character
	alt_front u_front (
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_push_data)
	);

	// queue between the two halves
	alt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	// back: line state machine and result transfers
	alt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
